// ===== sv/sldf_pkg.sv =====
`default_nettype none

package sldf_pkg;

   // Register map of the configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_SYNC_VALUE     = 2'd0,
      REG_FUNCTION_LIMIT = 2'd1,
      REG_LENGTH_LIMIT   = 2'd2,
      REG_UNUSED         = 2'd3
   } reg_index_type;

   localparam logic [7:0] SYNC_VALUE_RESET     = 8'hAA;
   localparam logic [8:0] FUNCTION_LIMIT_RESET = 9'h0F1;
   localparam logic [8:0] LENGTH_LIMIT_RESET   = 9'd100;

   // Function codes of the known sensor frames.
   localparam logic [7:0] CODE_SENSOR_A = 8'h0A;
   localparam logic [7:0] CODE_SENSOR_B = 8'h0D;
   localparam logic [7:0] CODE_SENSOR_C = 8'h0F;
   localparam logic [7:0] CODE_SENSOR_D = 8'h10;

   typedef enum logic [2:0] {
      PH_SYNC1 = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_CODE  = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_SUM   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] sync_value;
      logic [8:0] function_limit;
      logic [8:0] length_limit;
   } config_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [7:0] function_code;
      logic [7:0] payload_index;
      logic [7:0] frame_length;
      logic       checksum_ok;
      logic       function_known;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic code_is_known(input logic [7:0] code);
      return (code == CODE_SENSOR_A) || (code == CODE_SENSOR_B) ||
             (code == CODE_SENSOR_C) || (code == CODE_SENSOR_D);
   endfunction

endpackage

`default_nettype wire

// ===== sv/sldf_csr.sv =====
`default_nettype none

module sldf_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [sldf_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [sldf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [sldf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready,
   output sldf_pkg::config_type                 cfg
);

   sldf_pkg::config_type cfg_ff;
   sldf_pkg::config_type cfg_in;
   sldf_pkg::reg_index_type index;
   logic write_en;

   assign index    = sldf_pkg::reg_index_type'(paddr[3:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            sldf_pkg::REG_SYNC_VALUE:     cfg_in.sync_value     = pwdata[7:0];
            sldf_pkg::REG_FUNCTION_LIMIT: cfg_in.function_limit = pwdata[8:0];
            sldf_pkg::REG_LENGTH_LIMIT:   cfg_in.length_limit   = pwdata[8:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         sldf_pkg::REG_SYNC_VALUE:     prdata = {24'd0, cfg_ff.sync_value};
         sldf_pkg::REG_FUNCTION_LIMIT: prdata = {23'd0, cfg_ff.function_limit};
         sldf_pkg::REG_LENGTH_LIMIT:   prdata = {23'd0, cfg_ff.length_limit};
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value     <= sldf_pkg::SYNC_VALUE_RESET;
         cfg_ff.function_limit <= sldf_pkg::FUNCTION_LIMIT_RESET;
         cfg_ff.length_limit   <= sldf_pkg::LENGTH_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sldf_front.sv =====
`default_nettype none

// Frame parser: one received byte per cycle while the result queue has room, at most one result item per byte.
module sldf_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sldf_pkg::config_type      cfg,
   input  wire logic                      in_valid,
   input  wire logic [7:0]                in_byte,
   output logic                           in_ready,
   input  wire sldf_pkg::queue_status_type queue_status,
   output logic                           push,
   output sldf_pkg::result_type           push_item
);

   sldf_pkg::phase_type phase_ff, phase_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] received_ff, received_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] function_ff, function_in;
   logic [7:0] length_ff, length_in;

   logic accept;
   logic sync_match;
   logic code_ok;
   logic length_ok;
   logic [7:0] sum_next;

   assign in_ready   = !queue_status.full;
   assign accept     = in_valid && in_ready;
   assign sync_match = (in_byte == cfg.sync_value);
   assign code_ok    = ({1'b0, in_byte} < cfg.function_limit);
   assign length_ok  = ({1'b0, in_byte} < cfg.length_limit);
   assign sum_next   = sum_ff + in_byte;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            sldf_pkg::PH_SYNC1:
               phase_in = sync_match ? sldf_pkg::PH_SYNC2 : sldf_pkg::PH_SYNC1;
            sldf_pkg::PH_SYNC2:
               phase_in = sync_match ? sldf_pkg::PH_CODE : sldf_pkg::PH_SYNC1;
            sldf_pkg::PH_CODE:
               phase_in = code_ok ? sldf_pkg::PH_LEN : sldf_pkg::PH_SYNC1;
            sldf_pkg::PH_LEN:
               phase_in = length_ok ? sldf_pkg::PH_DATA : sldf_pkg::PH_SYNC1;
            sldf_pkg::PH_DATA: begin
               if (remaining_ff == 8'd0) begin
                  phase_in = sldf_pkg::PH_SYNC1;
               end else if (remaining_ff == 8'd1) begin
                  phase_in = sldf_pkg::PH_SUM;
               end else begin
                  phase_in = sldf_pkg::PH_DATA;
               end
            end
            default: phase_in = sldf_pkg::PH_SYNC1;
         endcase
      end
   end

   // Datapath updates and the result item.
   always_comb begin
      remaining_in = remaining_ff;
      received_in  = received_ff;
      sum_in       = sum_ff;
      function_in  = function_ff;
      length_in    = length_ff;
      push         = 1'b0;

      push_item.kind           = 1'b0;
      push_item.data_byte      = in_byte;
      push_item.function_code  = function_ff;
      push_item.payload_index  = received_ff;
      push_item.frame_length   = length_ff;
      push_item.checksum_ok    = 1'b0;
      push_item.function_known = 1'b0;

      if (accept) begin
         case (phase_ff)
            sldf_pkg::PH_SYNC1: begin
               if (sync_match) begin
                  sum_in = in_byte;
               end
            end
            sldf_pkg::PH_SYNC2: begin
               if (sync_match) begin
                  sum_in = sum_next;
               end
            end
            sldf_pkg::PH_CODE: begin
               if (code_ok) begin
                  function_in = in_byte;
                  sum_in      = sum_next;
               end
            end
            sldf_pkg::PH_LEN: begin
               if (length_ok) begin
                  length_in    = in_byte;
                  remaining_in = in_byte;
                  received_in  = 8'd0;
                  sum_in       = sum_next;
               end
            end
            sldf_pkg::PH_DATA: begin
               if (remaining_ff != 8'd0) begin
                  push         = 1'b1;
                  sum_in       = sum_next;
                  remaining_in = remaining_ff - 8'd1;
                  received_in  = received_ff + 8'd1;
               end
            end
            sldf_pkg::PH_SUM: begin
               push                     = 1'b1;
               push_item.kind           = 1'b1;
               push_item.checksum_ok    = (sum_ff == in_byte);
               push_item.function_known = sldf_pkg::code_is_known(function_ff);
            end
            default: push = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sldf_pkg::PH_SYNC1;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      remaining_ff <= remaining_in;
      received_ff  <= received_in;
      sum_ff       <= sum_in;
      function_ff  <= function_in;
      length_ff    <= length_in;
   end

endmodule

`default_nettype wire

// ===== sv/sldf_fifo.sv =====
`default_nettype none

module sldf_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire sldf_pkg::result_type  push_item,
   input  wire logic                  pop,
   output sldf_pkg::result_type       pop_item,
   output sldf_pkg::queue_status_type status
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   sldf_pkg::result_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == COUNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sldf_back.sv =====
`default_nettype none

// Output stage: moves one queued item per cycle into the result register while it is empty or its item is taken.
module sldf_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sldf_pkg::queue_status_type queue_status,
   input  wire sldf_pkg::result_type      queue_item,
   output logic                           pop,
   output logic                           out_valid,
   output sldf_pkg::result_type           out_item,
   input  wire logic                      out_ready
);

   logic                 valid_ff, valid_in;
   sldf_pkg::result_type item_ff, item_in;

   assign pop       = !queue_status.empty && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (pop) begin
         valid_in = 1'b1;
         item_in  = queue_item;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

// ===== sv/sync_length_checksum_deframer.sv =====
`default_nettype none

// Channel  Direction  Handshake                  Contents
// req      in         req_tvalid / req_tready    tdata[7:0] rx_byte
// rsp      out        rsp_tvalid / rsp_tready    tdata, tuser, tlast (see ports)
// csr      in         psel, penable, pready=1    sync_value, function_limit, length_limit
//
// One received byte is accepted every cycle while the result queue has room.
// The parser writes an item into the queue at the edge that accepts the byte
// causing it; rsp_tvalid rises when the output register takes the item from
// the queue, which it does once it is empty or its item is taken on rsp.
// The parser runs one compare, one 8-bit add and one counter step per byte,
// which sets the rate of one item per cycle while the result queue has room.
// Reset is synchronous; it clears the parser phase, the queue and the output
// register, and loads the register defaults.
// A stall on rsp fills the queue; req_tready falls only when it is full.

module sync_length_checksum_deframer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // Fields from bit 0: rx_byte[7:0].
   input  wire logic [7:0]  req_tdata,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // Fields from bit 0: data_byte[7:0], function_code[15:8],
   // payload_index[23:16], frame_length[31:24].
   output logic [31:0]      rsp_tdata,
   // Fields from bit 0: checksum_ok[0], function_known[1].
   output logic [1:0]       rsp_tuser,
   // High on the end-of-frame item (checksum byte seen).
   output logic             rsp_tlast,

   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [sldf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [sldf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [sldf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);

   sldf_pkg::config_type       cfg;
   sldf_pkg::queue_status_type queue_status;
   sldf_pkg::result_type       push_item;
   sldf_pkg::result_type       queue_item;
   sldf_pkg::result_type       out_item;
   logic                       push;
   logic                       pop;

   // Configuration registers; they are to be written only while no frame is in flight, which the user ensures.
   sldf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Front: the sync, code, length, payload and checksum parser.
   sldf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (req_tvalid),
      .in_byte      (req_tdata),
      .in_ready     (req_tready),
      .queue_status (queue_status),
      .push         (push),
      .push_item    (push_item)
   );

   // Short queue that lets the parser keep running while rsp is stalled.
   sldf_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (queue_item),
      .status    (queue_status)
   );

   // Back: the registered output stage.
   sldf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .queue_item   (queue_item),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_item     (out_item),
      .out_ready    (rsp_tready)
   );

   assign rsp_tdata = {out_item.frame_length, out_item.payload_index,
                       out_item.function_code, out_item.data_byte};
   assign rsp_tuser = {out_item.function_known, out_item.checksum_ok};
   assign rsp_tlast = out_item.kind;

endmodule

`default_nettype wire

// ===== sv/sldf_checker.sv =====
`default_nettype none

module sldf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // The queue and the output register are empty right after reset.
   assert property (@(posedge clock) reset |=> (!rsp_tvalid && req_tready))
      else $error("block not empty after reset");

   // A stalled result item holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result item changed");

   // The end-of-frame item counts exactly the announced number of payload items.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[23:16] == rsp_tdata[31:24]))
      else $error("end of frame count differs from frame length");

   // A payload item lies inside the announced length.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[23:16] < rsp_tdata[31:24]))
      else $error("payload index beyond frame length");

   // Payload items carry no frame status flags.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tuser == 2'b00))
      else $error("status flags set on a payload item");

endmodule

bind sync_length_checksum_deframer sldf_checker u_sldf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== sim/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Longest stretch without any item moving before the run is declared hung.
   // The slowest correct run stalls while the receiver holds off; everything
   // else moves an item much sooner.
   localparam int WATCHDOG_LIMIT = 4000;
   // Length of the deliberate receiver hold-off that fills the result queue.
   localparam int HOLD_CYCLES = 300;
   // A result reaches rsp through the queue and the output register; a byte
   // that yields no result may still be in the parser when the last result
   // arrives.  Wait this long before touching the registers or ending the run.
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_COUNT = 8;
   localparam int ITEMS_PER_PHASE = 140;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [sldf_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [sldf_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [sldf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   sync_length_checksum_deframer uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Parser model.  It keeps its own copy of the registers and the frame
   // state, and is advanced once for every byte the block accepts.
   // ------------------------------------------------------------------
   logic [7:0] sync_val   = sldf_pkg::SYNC_VALUE_RESET;
   logic [8:0] code_limit = sldf_pkg::FUNCTION_LIMIT_RESET;
   logic [8:0] len_limit  = sldf_pkg::LENGTH_LIMIT_RESET;

   sldf_pkg::phase_type parse_phase = sldf_pkg::PH_SYNC1;
   logic [7:0] bytes_left  = 8'd0;
   logic [7:0] bytes_seen  = 8'd0;
   logic [7:0] frame_sum   = 8'd0;
   logic [7:0] frame_code  = 8'd0;
   logic [7:0] frame_len   = 8'd0;

   // Results the block owes us, oldest first.
   sldf_pkg::result_type pending_results[$];

   int error_count    = 0;
   int items_accepted = 0;
   int bytes_sent     = 0;
   int results_seen   = 0;
   int frames_closed  = 0;
   int bad_sums_seen  = 0;
   int quiet_cycles   = 0;

   function automatic void parse_byte(input logic [7:0] b, output bit produced,
                                      output sldf_pkg::result_type r);
      produced = 1'b0;
      r = '0;
      case (parse_phase)
         sldf_pkg::PH_SYNC1: begin
            if (b == sync_val) begin
               frame_sum = b;
               parse_phase = sldf_pkg::PH_SYNC2;
            end
         end
         sldf_pkg::PH_SYNC2: begin
            if (b == sync_val) begin
               frame_sum = frame_sum + b;
               parse_phase = sldf_pkg::PH_CODE;
            end else begin
               parse_phase = sldf_pkg::PH_SYNC1;
            end
         end
         sldf_pkg::PH_CODE: begin
            if ({1'b0, b} < code_limit) begin
               frame_code = b;
               frame_sum = frame_sum + b;
               parse_phase = sldf_pkg::PH_LEN;
            end else begin
               parse_phase = sldf_pkg::PH_SYNC1;
            end
         end
         sldf_pkg::PH_LEN: begin
            if ({1'b0, b} < len_limit) begin
               frame_len = b;
               bytes_left = b;
               bytes_seen = 8'd0;
               frame_sum = frame_sum + b;
               parse_phase = sldf_pkg::PH_DATA;
            end else begin
               parse_phase = sldf_pkg::PH_SYNC1;
            end
         end
         sldf_pkg::PH_DATA: begin
            // A zero length leaves nothing to take: the byte is dropped.
            if (bytes_left == 8'd0) begin
               parse_phase = sldf_pkg::PH_SYNC1;
            end else begin
               produced = 1'b1;
               r.kind = 1'b0;
               r.data_byte = b;
               r.function_code = frame_code;
               r.payload_index = bytes_seen;
               r.frame_length = frame_len;
               frame_sum = frame_sum + b;
               bytes_left = bytes_left - 8'd1;
               bytes_seen = bytes_seen + 8'd1;
               if (bytes_left == 8'd0) parse_phase = sldf_pkg::PH_SUM;
            end
         end
         sldf_pkg::PH_SUM: begin
            produced = 1'b1;
            r.kind = 1'b1;
            r.data_byte = b;
            r.function_code = frame_code;
            r.payload_index = bytes_seen;
            r.frame_length = frame_len;
            r.checksum_ok = (frame_sum == b);
            r.function_known = (frame_code == sldf_pkg::CODE_SENSOR_A) ||
                               (frame_code == sldf_pkg::CODE_SENSOR_B) ||
                               (frame_code == sldf_pkg::CODE_SENSOR_C) ||
                               (frame_code == sldf_pkg::CODE_SENSOR_D);
            parse_phase = sldf_pkg::PH_SYNC1;
         end
         default: parse_phase = sldf_pkg::PH_SYNC1;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Directed table.  Rows marked silent or frame end carry their expected
   // outcome typed in; predicted rows rely on the parser model.
   // ------------------------------------------------------------------
   typedef enum {ROW_PREDICTED, ROW_SILENT, ROW_FRAME_END} row_check_type;

   typedef struct {
      logic [7:0]           rx;
      row_check_type        check;
      sldf_pkg::result_type frame_end;
   } stim_row_type;

   stim_row_type directed_rows[$];

   task automatic add_row(input logic [7:0] rx, input row_check_type check,
                          input logic [7:0] code, input logic [7:0] index,
                          input logic [7:0] length, input bit ok, input bit known);
      stim_row_type row;
      row.rx = rx;
      row.check = check;
      row.frame_end = '{kind: 1'b1, data_byte: rx, function_code: code,
                        payload_index: index, frame_length: length,
                        checksum_ok: ok, function_known: known};
      directed_rows.push_back(row);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected 0x%02h, actual 0x%02h",
                  $time, name, want, got);
         error_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // Monitor: predicts on every accepted byte, checks every accepted
   // result against the oldest expectation, and runs the watchdog.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      bit                   produced;
      bit                   moved;
      sldf_pkg::result_type predicted;
      sldf_pkg::result_type wanted;
      sldf_pkg::result_type seen;
      if (!reset) begin
         moved = 1'b0;
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            parse_byte(req_tdata, produced, predicted);
            // In the directed part, typed rows override what the model says.
            if (items_accepted < directed_rows.size()) begin
               case (directed_rows[items_accepted].check)
                  ROW_SILENT: produced = 1'b0;
                  ROW_FRAME_END: begin
                     produced = 1'b1;
                     predicted = directed_rows[items_accepted].frame_end;
                  end
                  default: ;
               endcase
            end
            if (produced) pending_results.push_back(predicted);
            items_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            seen.kind = rsp_tlast;
            seen.data_byte = rsp_tdata[7:0];
            seen.function_code = rsp_tdata[15:8];
            seen.payload_index = rsp_tdata[23:16];
            seen.frame_length = rsp_tdata[31:24];
            seen.checksum_ok = rsp_tuser[0];
            seen.function_known = rsp_tuser[1];
            results_seen++;
            if (seen.kind) frames_closed++;
            if (seen.kind && !seen.checksum_ok) bad_sums_seen++;
            if (pending_results.size() == 0) begin
               $display("%0t: result with no expectation waiting: %s 0x%08h tuser %b tlast %b",
                        $time, "tdata", rsp_tdata, rsp_tuser, rsp_tlast);
               error_count++;
            end else begin
               wanted = pending_results.pop_front();
               check_field("kind", {7'd0, wanted.kind}, {7'd0, seen.kind});
               check_field("data_byte", wanted.data_byte, seen.data_byte);
               check_field("function_code", wanted.function_code, seen.function_code);
               check_field("payload_index", wanted.payload_index, seen.payload_index);
               check_field("frame_length", wanted.frame_length, seen.frame_length);
               check_field("checksum_ok", {7'd0, wanted.checksum_ok},
                           {7'd0, seen.checksum_ok});
               check_field("function_known", {7'd0, wanted.function_known},
                           {7'd0, seen.function_known});
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) moved = 1'b1;
         if (moved) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                        $time, quiet_cycles, pending_results.size());
               $display("Simulation FAILED");
               $finish;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver.  It stalls at the rate the current phase asks, and on a toggle
   // of hold_req it holds off while hold_left counts down from HOLD_CYCLES.
   // ------------------------------------------------------------------
   int stall_pct = 0;
   int send_idle_pct = 0;
   bit hold_req = 1'b0;
   bit hold_seen = 1'b0;
   int hold_left = 0;

   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Sender side.
   // ------------------------------------------------------------------
   logic [7:0] frame_bytes[$];

   // Offers one byte, idling first as the current phase asks.  req_tvalid
   // gets exactly one assignment in any time step.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_frame_bytes(input int count);
      for (int i = 0; i < count; i++) send_byte(frame_bytes[i]);
   endtask

   // Builds a whole frame under the current register settings: two sync
   // bytes, code, length, payload, and the 8-bit sum (spoiled on request).
   task automatic build_frame(input logic [7:0] code, input int len, input bit bad_sum);
      logic [7:0] sum;
      logic [7:0] b;
      frame_bytes.delete();
      frame_bytes.push_back(sync_val);
      frame_bytes.push_back(sync_val);
      frame_bytes.push_back(code);
      frame_bytes.push_back(8'(len));
      sum = sync_val + sync_val + code + 8'(len);
      repeat (len) begin
         b = 8'($urandom_range(255));
         frame_bytes.push_back(b);
         sum = sum + b;
      end
      if (bad_sum) sum = sum ^ 8'($urandom_range(255, 1));
      frame_bytes.push_back(sum);
   endtask

   // One unit of random traffic: mostly well-formed frames with random
   // content, the rest cut short, broken at a header check, or noise.
   task automatic send_random_unit();
      int         code_max;
      int         len_max;
      int         len;
      int         pick;
      logic [7:0] code;
      code_max = (code_limit > 9'd255) ? 255 : int'(code_limit) - 1;
      len_max = (len_limit > 9'd255) ? 255 : int'(len_limit) - 1;
      if ($urandom_range(99) < 20) begin
         case ($urandom_range(3))
            0: code = sldf_pkg::CODE_SENSOR_A;
            1: code = sldf_pkg::CODE_SENSOR_B;
            2: code = sldf_pkg::CODE_SENSOR_C;
            default: code = sldf_pkg::CODE_SENSOR_D;
         endcase
      end else begin
         code = 8'($urandom_range(code_max));
      end
      // Payloads stay short; now and then one spans the whole length range.
      if ($urandom_range(99) < 3) len = $urandom_range(len_max);
      else len = $urandom_range((len_max < 10) ? len_max : 10);
      build_frame(code, len, $urandom_range(99) < 10);
      pick = $urandom_range(99);
      if (pick < 75) begin
         send_frame_bytes(frame_bytes.size());
      end else if (pick < 85) begin
         send_frame_bytes($urandom_range(frame_bytes.size() - 1, 1));
      end else if (pick < 93) begin
         case ($urandom_range(2))
            0: frame_bytes[1] = sync_val ^ 8'($urandom_range(255, 1));
            1: if (code_limit <= 9'd255)
                  frame_bytes[2] = 8'($urandom_range(255, code_limit));
            default: if (len_limit <= 9'd255)
                  frame_bytes[3] = 8'($urandom_range(255, len_limit));
         endcase
         send_frame_bytes(4);
      end else begin
         repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
      end
   endtask

   // Stops offering and waits until every expected result has arrived.
   // It always lets at least one edge pass, so req_tvalid is never
   // assigned twice in one step.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_csr(input sldf_pkg::reg_index_type index,
                            input logic [sldf_pkg::CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         sldf_pkg::REG_SYNC_VALUE:     sync_val = value[7:0];
         sldf_pkg::REG_FUNCTION_LIMIT: code_limit = value[8:0];
         sldf_pkg::REG_LENGTH_LIMIT:   len_limit = value[8:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      logic [7:0] sync_set [PHASE_COUNT];
      logic [8:0] flim_set [PHASE_COUNT];
      logic [8:0] llim_set [PHASE_COUNT];
      int         phase_end;
      int         pause_at;
      bit         paused;

      // Directed rows, all under the reset settings (sync 0xAA, code
      // limit 0xF1, length limit 100).
      //       rx     check          code   idx    len    ok    known
      add_row(8'hAA, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      // A broken second sync byte sends the parser back to hunting.
      add_row(8'h55, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'hAA, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'hAA, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'h0A, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'h02, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'h00, ROW_PREDICTED, 8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'hFF, ROW_PREDICTED, 8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'h5F, ROW_FRAME_END, 8'h0A, 8'd2,  8'd2,  1'b1, 1'b1);
      // A code equal to the limit is rejected.
      add_row(8'hAA, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'hAA, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'hF1, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      // The largest accepted code with a zero length: the byte after the
      // length is dropped and no result is given.
      add_row(8'hAA, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'hAA, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'hF0, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'h00, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'h37, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      // A length of 0xAA is over the limit and equals the sync value; it is
      // not rechecked as a first sync byte, so the frame below parses cleanly.
      add_row(8'hAA, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'hAA, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'h10, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'hAA, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'hAA, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'hAA, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'h0F, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'h01, ROW_SILENT,    8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      add_row(8'h80, ROW_PREDICTED, 8'h00, 8'd0,  8'd0,  1'b0, 1'b0);
      // Bad checksum: the frame end is still reported, with the flag low.
      add_row(8'hE5, ROW_FRAME_END, 8'h0F, 8'd1,  8'd1,  1'b0, 1'b1);

      // Register settings per phase: defaults, the extremes, then random.
      sync_set[0] = 8'hAA; flim_set[0] = 9'd241; llim_set[0] = 9'd100;
      sync_set[1] = 8'h00; flim_set[1] = 9'd256; llim_set[1] = 9'd256;
      sync_set[2] = 8'hFF; flim_set[2] = 9'd1;   llim_set[2] = 9'd256;
      sync_set[3] = 8'h55; flim_set[3] = 9'd17;  llim_set[3] = 9'd1;
      for (int p = 4; p < PHASE_COUNT; p++) begin
         sync_set[p] = 8'($urandom_range(255));
         flim_set[p] = 9'($urandom_range(256, 1));
         llim_set[p] = 9'($urandom_range(256, 1));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_byte(directed_rows[i].rx);
      drain_results();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         // Registers change only with nothing in flight.
         send_idle_pct = 0;
         stall_pct = 0;
         repeat (SETTLE_CYCLES) @(posedge clock);
         write_csr(sldf_pkg::REG_SYNC_VALUE, {24'd0, sync_set[p]});
         write_csr(sldf_pkg::REG_FUNCTION_LIMIT, {23'd0, flim_set[p]});
         write_csr(sldf_pkg::REG_LENGTH_LIMIT, {23'd0, llim_set[p]});
         // A write to the spare address must leave all settings alone.
         if (p == 4) write_csr(sldf_pkg::REG_UNUSED, $urandom);

         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 6; stall_pct = 6; end
         endcase

         // With no idling, hold the receiver off for a long stretch while
         // frames keep coming, so the queue fills and req_tready drops.
         if (p == 0) hold_req <= ~hold_req;
         // The widest frame: largest code and length, index up to 255.
         if (p == 1) begin
            build_frame(8'hFF, 255, 1'b0);
            send_frame_bytes(frame_bytes.size());
         end

         phase_end = bytes_sent + ITEMS_PER_PHASE;
         pause_at = bytes_sent + ITEMS_PER_PHASE / 2;
         paused = 1'b0;
         while (bytes_sent < phase_end) begin
            send_random_unit();
            // Once, mid-phase, the sender waits for every result to arrive.
            if (p == 2 && !paused && bytes_sent >= pause_at) begin
               drain_results();
               paused = 1'b1;
            end
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d items over %0d register settings, including a long receiver hold-off",
               items_accepted, PHASE_COUNT + 1);
      $display("Checked %0d results, %0d frame ends (%0d with a bad checksum), %0d mismatches",
               results_seen, frames_closed, bad_sums_seen, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
